// ===== design/pcx_8bit_rle_decoder_top_defines.svh =====
// Assertion macros for the 8-bit PCX run-length decoder.
// Included by the top level; no other dependencies.
`ifndef PCX_8BIT_RLE_DECODER_TOP_DEFINES_SVH
`define PCX_8BIT_RLE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PCX8_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcx8 assertion failed");
`define PCX8_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pcx8 assertion failed");
`else
`define PCX8_ASSERT_IMPLIES(label, ante, cons)
`define PCX8_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== design/pcx8_pkg.sv =====
// Shared types and constants of the 8-bit PCX run-length decoder.
// No dependencies; used by every module of the block.
package pcx8_pkg;

  localparam int MAX_LINE = 2048;
  localparam logic [7:0] RUN_MARK = 8'hC0;

  typedef enum logic [1:0] {
    CFG_STRIDE = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_TRUNC = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [11:0] stride;
    logic [11:0] width;
    logic [11:0] height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [10:0] column;
    logic [10:0] row;
    logic        last;
    logic        done;
    logic        trunc;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_RUN   = 2'd1,
    BK_FLUSH = 2'd2
  } back_state_t;

  // Zero means one; anything above the line limit is held at the limit.
  function automatic logic [11:0] clamp_cfg(input logic [11:0] v);
    logic [11:0] r;
    if (v == 12'd0) begin
      r = 12'd1;
    end else if (v > 12'(MAX_LINE)) begin
      r = 12'(MAX_LINE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/pcx8_front.sv =====
// Front end: turns compressed bytes into placement and truncation commands.
// Depends on pcx8_pkg.
module pcx8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  output logic             cmd_push,
  output pcx8_pkg::cmd_t   cmd_wdata,
  input  logic             cmd_full
);

  logic       awaiting_r, awaiting_nxt;
  logic [5:0] pending_r, pending_nxt;
  logic       accept;

  assign in_tready = !cmd_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    cmd_push     = 1'b0;
    cmd_wdata.kind  = pcx8_pkg::CMD_PLACE;
    cmd_wdata.value = in_tdata;
    cmd_wdata.count = 6'd1;
    if (accept) begin
      if (in_tlast) begin
        cmd_push       = 1'b1;
        cmd_wdata.kind = pcx8_pkg::CMD_TRUNC;
        awaiting_nxt   = 1'b0;
        pending_nxt    = 6'd0;
      end else if (awaiting_r) begin
        // A run count of zero still places the value once.
        cmd_push        = 1'b1;
        cmd_wdata.count = (pending_r == 6'd0) ? 6'd1 : pending_r;
        awaiting_nxt    = 1'b0;
        pending_nxt     = 6'd0;
      end else if (in_tdata < pcx8_pkg::RUN_MARK) begin
        cmd_push = 1'b1;
      end else begin
        pending_nxt  = in_tdata[5:0];
        awaiting_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pending_r  <= 6'd0;
    end else begin
      awaiting_r <= awaiting_nxt;
      pending_r  <= pending_nxt;
    end
  end

endmodule

// ===== design/pcx8_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on pcx8_pkg for the command type.
module pcx8_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcx8_pkg::cmd_t wdata,
  input  logic           pop,
  output pcx8_pkg::cmd_t rdata,
  output logic           full,
  output logic           not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcx8_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/pcx8_back.sv =====
// Back end: places decoded bytes into strides and emits pixel results.
// Depends on pcx8_pkg; fed from pcx8_cmd_fifo.
module pcx8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pcx8_pkg::cfg_t  cfg,
  input  logic            cmd_valid,
  input  pcx8_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            res_valid,
  input  logic            res_ready,
  output pcx8_pkg::res_t  res
);

  pcx8_pkg::back_state_t state_r, state_nxt;
  logic           finished_r, finished_nxt;
  logic [10:0]    col_r, col_nxt;
  logic [10:0]    row_r, row_nxt;
  logic [5:0]     rem_r, rem_nxt;
  logic [7:0]     val_r, val_nxt;
  logic           held_valid_r, held_valid_nxt;
  pcx8_pkg::res_t held_r, held_nxt;
  logic           out_valid_r, out_valid_nxt;
  pcx8_pkg::res_t out_r, out_nxt;

  logic [11:0] width_eff, col_x, row_x, room, skip_k, step_n, col_sum;
  logic [5:0]  rem_after;
  logic        can_push, is_pixel, wrap, last_row, stall;
  pcx8_pkg::res_t pix_res, trunc_res;

  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Pixels kept per row never exceed the stride.
  assign width_eff = (cfg.width < cfg.stride) ? cfg.width : cfg.stride;
  assign col_x     = {1'b0, col_r};
  assign row_x     = {1'b0, row_r};
  assign can_push  = !out_valid_r || res_ready;
  assign is_pixel  = col_x < width_eff;
  assign room      = cfg.stride - col_x;

  // Padding is skipped up to the stride end in one step.
  always_comb begin
    if (col_x >= cfg.stride) begin
      skip_k = 12'd1;
    end else if (room > {6'd0, rem_r}) begin
      skip_k = {6'd0, rem_r};
    end else begin
      skip_k = room;
    end
  end

  assign step_n    = is_pixel ? 12'd1 : skip_k;
  assign col_sum   = col_x + step_n;
  assign wrap      = col_sum >= cfg.stride;
  assign last_row  = (row_x + 12'd1) >= cfg.height;
  assign rem_after = rem_r - step_n[5:0];
  assign stall     = is_pixel && held_valid_r && !can_push;

  always_comb begin
    pix_res.pixel  = val_r;
    pix_res.column = col_r;
    pix_res.row    = row_r;
    pix_res.last   = 1'b0;
    pix_res.done   = ((row_x + 12'd1) == cfg.height) && ((col_x + 12'd1) == width_eff);
    pix_res.trunc  = 1'b0;
    trunc_res.pixel  = 8'd0;
    trunc_res.column = col_r;
    trunc_res.row    = row_r;
    trunc_res.last   = 1'b0;
    trunc_res.done   = 1'b0;
    trunc_res.trunc  = 1'b1;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcx8_pkg::BK_IDLE: begin
        if (cmd_valid && !finished_r) begin
          state_nxt = (cmd.kind == pcx8_pkg::CMD_TRUNC) ? pcx8_pkg::BK_FLUSH
                                                        : pcx8_pkg::BK_RUN;
        end
      end
      pcx8_pkg::BK_RUN: begin
        if (!stall && ((rem_after == 6'd0) || (wrap && last_row))) begin
          state_nxt = pcx8_pkg::BK_FLUSH;
        end
      end
      pcx8_pkg::BK_FLUSH: begin
        if (!held_valid_r || can_push) begin
          state_nxt = pcx8_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pcx8_pkg::BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    cmd_pop        = 1'b0;
    finished_nxt   = finished_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    rem_nxt        = rem_r;
    val_nxt        = val_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && !res_ready;
    out_nxt        = out_r;
    unique case (state_r)
      pcx8_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!finished_r) begin
            if (cmd.kind == pcx8_pkg::CMD_TRUNC) begin
              held_nxt       = trunc_res;
              held_valid_nxt = 1'b1;
              finished_nxt   = 1'b1;
            end else begin
              val_nxt = cmd.value;
              rem_nxt = cmd.count;
            end
          end
        end
      end
      pcx8_pkg::BK_RUN: begin
        if (!stall) begin
          rem_nxt = rem_after;
          if (wrap) begin
            col_nxt = 11'd0;
            if (last_row) begin
              finished_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 11'd1;
            end
          end else begin
            col_nxt = col_sum[10:0];
          end
          if (is_pixel) begin
            // The held pixel is not the last one of this request.
            if (held_valid_r) begin
              out_nxt       = held_r;
              out_valid_nxt = 1'b1;
            end
            held_nxt       = pix_res;
            held_valid_nxt = 1'b1;
          end
        end
      end
      pcx8_pkg::BK_FLUSH: begin
        if (held_valid_r && can_push) begin
          out_nxt        = held_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          held_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pcx8_pkg::BK_IDLE;
      finished_r   <= 1'b0;
      col_r        <= 11'd0;
      row_r        <= 11'd0;
      rem_r        <= 6'd0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      finished_r   <= finished_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      rem_r        <= rem_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== design/pcx_8bit_rle_decoder_top.sv =====
// Top level of the 8-bit PCX run-length decoder: config registers and wiring.
// Depends on pcx8_pkg, pcx8_front, pcx8_cmd_fifo, pcx8_back and the defines header.
`include "pcx_8bit_rle_decoder_top_defines.svh"

// The block expands the compressed pixel stream of an 8-bit PCX image into
// one result per kept pixel, tagged with its column and row. Each input
// request carries one compressed byte, or with in_tlast high the end of the
// stream. A byte below 0xC0 is a literal; any other byte is a run header whose
// low six bits give a count (zero counts as one) for the byte that follows.
// Headers produce no result. Decoded bytes fill strides of stride_bytes and
// only the first image_width bytes of each are emitted; out_tlast marks the
// final result caused by one input request. After image_height strides the
// block is finished and drops all input until reset; a stream end before
// that gives one result with the truncated flag set. Register values of zero
// read as one and values above 2048 read as 2048. Timing: the front end takes
// a byte and queues a command for the back end, which places one pixel per
// cycle unless its output is stalled. A literal passes the back end through
// fetch, place and hand-off of the held result, and a run through fetch, its
// placements and the hand-off; each stretch of stride padding inside a run
// is skipped at once. The back end's one-pixel-per-cycle placement sets the
// sustained input rate; the command queue lets the front end keep taking
// bytes while a run is being expanded.
module pcx_8bit_rle_decoder_top #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  // Compressed input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  // Decoded pixel stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pixel, [18:8] pixel_column, [29:19] pixel_row
  output logic        out_tlast,  // last result of one input request
  output logic [1:0]  out_tuser   // [0] image_done, [1] truncated
);

  logic [11:0]    stride_r, stride_nxt;
  logic [11:0]    width_r, width_nxt;
  logic [11:0]    height_r, height_nxt;
  pcx8_pkg::cfg_t cfg;

  logic           cmd_push, cmd_full, cmd_pop, cmd_valid;
  pcx8_pkg::cmd_t cmd_wdata, cmd_rdata;
  pcx8_pkg::res_t res;

  // Registers hold the already clamped values, so the back end sees legal
  // geometry only.
  always_comb begin
    stride_nxt = stride_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_addr)
        pcx8_pkg::CFG_STRIDE: stride_nxt = pcx8_pkg::clamp_cfg(cfg_wdata);
        pcx8_pkg::CFG_WIDTH:  width_nxt  = pcx8_pkg::clamp_cfg(cfg_wdata);
        pcx8_pkg::CFG_HEIGHT: height_nxt = pcx8_pkg::clamp_cfg(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= 12'd1;
      width_r  <= 12'd1;
      height_r <= 12'd1;
    end else begin
      stride_r <= stride_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign cfg.stride = stride_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

  pcx8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd_push  (cmd_push),
    .cmd_wdata (cmd_wdata),
    .cmd_full  (cmd_full)
  );

  pcx8_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .wdata     (cmd_wdata),
    .pop       (cmd_pop),
    .rdata     (cmd_rdata),
    .full      (cmd_full),
    .not_empty (cmd_valid)
  );

  pcx8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.row, res.column, res.pixel};
  assign out_tlast = res.last;
  assign out_tuser = {res.trunc, res.done};

  // A command is never pushed into a full queue.
  `PCX8_ASSERT_NEVER(a_no_overflow, cmd_push && cmd_full)
  // Nothing follows a truncation result within its request.
  `PCX8_ASSERT_IMPLIES(a_trunc_last, out_tvalid && out_tuser[1], out_tlast)
  // Only padding can follow the final pixel, so it always closes its request.
  `PCX8_ASSERT_IMPLIES(a_done_last, out_tvalid && out_tuser[0], out_tlast)
  // A result is either a finished image pixel or a truncation, never both.
  `PCX8_ASSERT_NEVER(a_done_trunc, out_tvalid && out_tuser[0] && out_tuser[1])

endmodule
